// File: rtl/core/mqf_pkg.sv
// mqf_pkg: shared constants and types for the multi-queue output buffer
// used by mqf_ram users and by multi_queue_fifo_with_depth_stats
package mqf_pkg;

    // queue geometry
    localparam int QUEUE_DEPTH     = 64;
    localparam int NUM_PORTS       = 3;
    localparam int QUEUES_PER_PORT = 2;
    localparam int NUM_QUEUES      = NUM_PORTS * QUEUES_PER_PORT;

    // field widths fixed by the interface
    localparam int PORT_W   = 2;
    localparam int QSEL_W   = 1;
    localparam int HANDLE_W = 16;
    localparam int STAMP_W  = 32;
    localparam int STATUS_W = 2;
    localparam int TOTAL_W  = 32;

    // derived widths
    localparam int QIDX_W  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int OCC_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRY_W = HANDLE_W + STAMP_W;
    localparam int STORE_DEPTH = NUM_QUEUES * QUEUE_DEPTH;
    localparam int ADDR_W  = $clog2(STORE_DEPTH);

    // result status codes
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // operation codes
    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    typedef logic [PTR_W-1:0]   ptr_t;
    typedef logic [OCC_W-1:0]   occ_t;
    typedef logic [TOTAL_W-1:0] total_t;

    // result carried from the lookup stage to the output register
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                deq_ok;
        occ_t                seen;
        occ_t                peak;
        total_t              total;
    } mqf_res_t;

endpackage

// File: rtl/core/mqf_ram.sv
// mqf_ram: generic single write port, single read port ram with registered read
// no package dependencies
module mqf_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 384,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read, holds when not enabled
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/multi_queue_fifo_with_depth_stats.sv
// multi_queue_fifo_with_depth_stats: six packet handle fifos with per-queue depth stats
// depends on mqf_pkg and mqf_ram
//
//  channel | ports                                              | dir
//  --------+----------------------------------------------------+-----
//  s_      | valid ready kind port queue_sel packet_handle      | in
//          | arrival_stamp                                      |
//  m_      | valid ready status out_handle out_stamp depth_seen | out
//          | peak_depth resident_total                          |
//
// one word per cycle sustained while m_ready is high; the result passes through the lookup
// stage, then the output register where the ram data joins.
// queue state sits in flops and updates at acceptance, so the next word sees it at once.
// aresetn (synchronous, active low) empties all queues and clears the statistics;
// the entry ram is not cleared, so there is no sweep after reset.
// s_ready drops only while both stages hold words and m_ready is low.
module multi_queue_fifo_with_depth_stats
    import mqf_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_kind,
    input  logic [PORT_W-1:0]   s_port,
    input  logic [QSEL_W-1:0]   s_queue_sel,
    input  logic [HANDLE_W-1:0] s_packet_handle,
    input  logic [STAMP_W-1:0]  s_arrival_stamp,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic [HANDLE_W-1:0] m_out_handle,
    output logic [STAMP_W-1:0]  m_out_stamp,
    output logic [OCC_W-1:0]    m_depth_seen,
    output logic [OCC_W-1:0]    m_peak_depth,
    output logic [TOTAL_W-1:0]  m_resident_total
);

    // per-queue state
    ptr_t   head_reg  [NUM_QUEUES];
    ptr_t   tail_reg  [NUM_QUEUES];
    occ_t   occ_reg   [NUM_QUEUES];
    occ_t   peak_reg  [NUM_QUEUES];
    total_t total_reg [NUM_QUEUES];

    // lookup stage and output register
    logic     p1_valid_reg;
    mqf_res_t p1_res_reg;
    mqf_res_t p1_res_next;
    logic     m_valid_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic [HANDLE_W-1:0] m_handle_reg;
    logic [STAMP_W-1:0]  m_stamp_reg;
    occ_t     m_seen_reg;
    occ_t     m_peak_reg;
    total_t   m_total_reg;

    logic                accept;
    logic                p1_move;
    logic                q_exists;
    logic [QIDX_W-1:0]   q_idx;
    ptr_t                head_cur;
    ptr_t                tail_cur;
    occ_t                occ_cur;
    occ_t                peak_cur;
    total_t              total_cur;
    logic                is_full;
    logic                is_empty;
    logic                do_enq;
    logic                do_deq;
    logic [TOTAL_W:0]    sum_wide;
    total_t              total_next;
    occ_t                peak_next;
    ptr_t                head_next;
    ptr_t                tail_next;
    logic [ADDR_W-1:0]   base_addr;
    logic [ENTRY_W-1:0]  rd_entry;

    // handshake
    assign p1_move = !m_valid_reg || m_ready;
    assign s_ready = !p1_valid_reg || p1_move;
    assign accept  = s_valid && s_ready;

    // queue lookup
    always_comb begin
        q_exists = (int'(s_port) < NUM_PORTS) && (int'(s_queue_sel) < QUEUES_PER_PORT);
        q_idx    = QIDX_W'(int'(s_port) * QUEUES_PER_PORT + int'(s_queue_sel));
        head_cur  = head_reg[q_idx];
        tail_cur  = tail_reg[q_idx];
        occ_cur   = occ_reg[q_idx];
        peak_cur  = peak_reg[q_idx];
        total_cur = total_reg[q_idx];
    end

    // decide the operation and the new statistics
    always_comb begin
        is_full  = (occ_cur == OCC_W'(QUEUE_DEPTH));
        is_empty = (occ_cur == '0);
        do_enq   = accept && q_exists && (s_kind == OP_ENQ) && !is_full;
        do_deq   = accept && q_exists && (s_kind == OP_DEQ) && !is_empty;

        sum_wide   = {1'b0, total_cur} + (TOTAL_W + 1)'(occ_cur);
        total_next = sum_wide[TOTAL_W] ? '1 : sum_wide[TOTAL_W-1:0];
        peak_next  = (occ_cur > peak_cur) ? occ_cur : peak_cur;

        head_next = (head_cur == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_cur + 1'b1;
        tail_next = (tail_cur == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_cur + 1'b1;

        base_addr = ADDR_W'(q_idx) * ADDR_W'(QUEUE_DEPTH);

        // result fields known at lookup time
        p1_res_next.deq_ok = 1'b0;
        p1_res_next.seen   = '0;
        p1_res_next.peak   = peak_cur;
        p1_res_next.total  = total_cur;
        if (!q_exists) begin
            p1_res_next.status = (s_kind == OP_DEQ) ? ST_EMPTY : ST_FULL;
            p1_res_next.peak   = '0;
            p1_res_next.total  = '0;
        end else if (s_kind == OP_ENQ) begin
            p1_res_next.status = is_full ? ST_FULL : ST_DONE;
        end else if (is_empty) begin
            p1_res_next.status = ST_EMPTY;
        end else begin
            p1_res_next.status = ST_DONE;
            p1_res_next.deq_ok = 1'b1;
            p1_res_next.seen   = occ_cur;
            p1_res_next.peak   = peak_next;
            p1_res_next.total  = total_next;
        end
    end

    // entry store
    mqf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (STORE_DEPTH)
    ) u_entry_ram (
        .aclk    (aclk),
        .wr_en   (do_enq),
        .wr_addr (base_addr + ADDR_W'(tail_cur)),
        .wr_data ({s_packet_handle, s_arrival_stamp}),
        .rd_en   (do_deq),
        .rd_addr (base_addr + ADDR_W'(head_cur)),
        .rd_data (rd_entry)
    );

    // per-queue state update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_QUEUES; i++) begin
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                occ_reg[i]   <= '0;
                peak_reg[i]  <= '0;
                total_reg[i] <= '0;
            end
        end else if (do_enq) begin
            tail_reg[q_idx] <= tail_next;
            occ_reg[q_idx]  <= occ_cur + 1'b1;
        end else if (do_deq) begin
            head_reg[q_idx]  <= head_next;
            occ_reg[q_idx]   <= occ_cur - 1'b1;
            peak_reg[q_idx]  <= peak_next;
            total_reg[q_idx] <= total_next;
        end
    end

    // lookup stage control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            p1_valid_reg <= s_valid;
        end
    end

    // lookup stage payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_res_reg <= p1_res_next;
        end
    end

    // output register control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (p1_move) begin
            m_valid_reg <= p1_valid_reg;
        end
    end

    // output register payload, ram data joins here
    always_ff @(posedge aclk) begin
        if (p1_move && p1_valid_reg) begin
            m_status_reg <= p1_res_reg.status;
            m_handle_reg <= p1_res_reg.deq_ok ? rd_entry[ENTRY_W-1:STAMP_W] : '0;
            m_stamp_reg  <= p1_res_reg.deq_ok ? rd_entry[STAMP_W-1:0] : '0;
            m_seen_reg   <= p1_res_reg.seen;
            m_peak_reg   <= p1_res_reg.peak;
            m_total_reg  <= p1_res_reg.total;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_out_handle     = m_handle_reg;
    assign m_out_stamp      = m_stamp_reg;
    assign m_depth_seen     = m_seen_reg;
    assign m_peak_depth     = m_peak_reg;
    assign m_resident_total = m_total_reg;

`ifndef NO_ASSERTIONS
    // a pending word must not be overwritten while the output is stalled
    a_hold_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (p1_valid_reg && m_valid_reg && !m_ready) |-> !s_ready)
        else $error("lookup stage accepted a word while stalled");

    // the addressed queue never holds more than its depth
    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && q_exists) |-> (occ_cur <= OCC_W'(QUEUE_DEPTH)))
        else $error("queue occupancy beyond depth");

    // a dequeue that finds data is carried as a ram read
    a_deq_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        do_deq |=> (p1_valid_reg && p1_res_reg.deq_ok))
        else $error("dequeue lost between lookup and ram read");

    // a nonzero depth is only reported on a good dequeue, within the peak
    a_seen_peak: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_depth_seen != '0)) |->
            ((m_status == ST_DONE) && (m_peak_depth >= m_depth_seen)))
        else $error("depth_seen inconsistent with status or peak");
`endif

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// tb: testbench for multi_queue_fifo_with_depth_stats, with a shadow model of the six fifos
// and their depth statistics checked word by word; depends on mqf_pkg and the rtl

module tb;
    import mqf_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 10;
    localparam int QUIET_WORDS    = 200;

    // one held fifo entry and one result word as the block reports it
    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [STAMP_W-1:0]  stamp;
    } held_word_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HANDLE_W-1:0] handle;
        logic [STAMP_W-1:0]  stamp;
        occ_t                seen;
        occ_t                peak;
        total_t              total;
    } buffer_result_t;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic                s_kind;
    logic [PORT_W-1:0]   s_port;
    logic [QSEL_W-1:0]   s_queue_sel;
    logic [HANDLE_W-1:0] s_packet_handle;
    logic [STAMP_W-1:0]  s_arrival_stamp;
    logic                m_valid;
    logic                m_ready;
    logic [STATUS_W-1:0] m_status;
    logic [HANDLE_W-1:0] m_out_handle;
    logic [STAMP_W-1:0]  m_out_stamp;
    occ_t                m_depth_seen;
    occ_t                m_peak_depth;
    total_t              m_resident_total;

    // shadow state of the buffer
    held_word_t     shadow_fifo [NUM_QUEUES][$];
    occ_t           shadow_peak [NUM_QUEUES];
    total_t         shadow_total [NUM_QUEUES];
    buffer_result_t owed_results [$];

    int   mismatch_count = 0;
    int   idle_cycles = 0;
    logic idle_en = 1'b1;

    multi_queue_fifo_with_depth_stats DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_kind           (s_kind),
        .s_port           (s_port),
        .s_queue_sel      (s_queue_sel),
        .s_packet_handle  (s_packet_handle),
        .s_arrival_stamp  (s_arrival_stamp),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_out_handle     (m_out_handle),
        .m_out_stamp      (m_out_stamp),
        .m_depth_seen     (m_depth_seen),
        .m_peak_depth     (m_peak_depth),
        .m_resident_total (m_resident_total)
    );

    always #5 aclk = ~aclk;

    // work out the result of one accepted word and update the shadow state
    function automatic void predict_buffer_result(input logic kind,
                                                  input logic [PORT_W-1:0] port,
                                                  input logic [QSEL_W-1:0] qsel,
                                                  input logic [HANDLE_W-1:0] handle,
                                                  input logic [STAMP_W-1:0] stamp);
        buffer_result_t   r;
        held_word_t       w;
        int               q;
        logic [TOTAL_W:0] sum;
        r = '0;
        if (port >= NUM_PORTS || qsel >= QUEUES_PER_PORT) begin
            // nonexistent queue: nothing changes, stats read as zero
            r.status = (kind == OP_DEQ) ? ST_EMPTY : ST_FULL;
        end else begin
            q = int'(port) * QUEUES_PER_PORT + int'(qsel);
            if (kind == OP_ENQ) begin
                if (shadow_fifo[q].size() >= QUEUE_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    w.handle = handle;
                    w.stamp  = stamp;
                    shadow_fifo[q].push_back(w);
                    r.status = ST_DONE;
                end
            end else if (shadow_fifo[q].size() == 0) begin
                r.status = ST_EMPTY;
            end else begin
                r.seen = occ_t'(shadow_fifo[q].size());
                w = shadow_fifo[q].pop_front();
                r.handle = w.handle;
                r.stamp  = w.stamp;
                // running total saturates at all ones
                sum = {1'b0, shadow_total[q]} + r.seen;
                shadow_total[q] = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
                if (r.seen > shadow_peak[q]) shadow_peak[q] = r.seen;
                r.status = ST_DONE;
            end
            r.peak  = shadow_peak[q];
            r.total = shadow_total[q];
        end
        owed_results.push_back(r);
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= 50)
            $display("tb: %s mismatch at %0t: got %0h, want %0h", field, $time, got, want);
    endtask

    // send one word, with a random gap in front of it when idling is on
    task automatic send_word(input logic kind, input logic [PORT_W-1:0] port,
                             input logic [QSEL_W-1:0] qsel,
                             input logic [HANDLE_W-1:0] handle,
                             input logic [STAMP_W-1:0] stamp);
        int gap;
        gap = 0;
        if (idle_en && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 15);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_kind          <= kind;
        s_port          <= port;
        s_queue_sel     <= qsel;
        s_packet_handle <= handle;
        s_arrival_stamp <= stamp;
        do @(posedge aclk); while (!s_ready);
        predict_buffer_result(kind, port, qsel, handle, stamp);
        @(negedge aclk);
    endtask

    // sender stops until every owed result is back
    task automatic hold_off_until_drained();
        s_valid <= 1'b0;
        while (owed_results.size() != 0) @(negedge aclk);
    endtask

    // empty and nonexistent queues, payload extremes, one word through every queue
    task automatic test_directed();
        send_word(OP_DEQ, 2'd0, 1'b0, '1, '1);
        send_word(OP_ENQ, 2'd3, 1'b0, 16'h1234, 32'h89ab_cdef);
        send_word(OP_ENQ, 2'd3, 1'b1, '1, '1);
        send_word(OP_DEQ, 2'd3, 1'b1, '0, '0);
        send_word(OP_ENQ, 2'd0, 1'b0, '1, '1);
        send_word(OP_ENQ, 2'd0, 1'b0, '0, '0);
        send_word(OP_DEQ, 2'd0, 1'b0, 16'h5a5a, 32'h5a5a_5a5a);
        send_word(OP_DEQ, 2'd0, 1'b0, '0, '0);
        send_word(OP_DEQ, 2'd0, 1'b0, '0, '0);
        for (int q = 0; q < NUM_QUEUES; q++) begin
            send_word(OP_ENQ, PORT_W'(q / QUEUES_PER_PORT), QSEL_W'(q % QUEUES_PER_PORT),
                      HANDLE_W'($urandom()), $urandom());
            send_word(OP_DEQ, PORT_W'(q / QUEUES_PER_PORT), QSEL_W'(q % QUEUES_PER_PORT),
                      HANDLE_W'($urandom()), $urandom());
        end
    endtask

    // fill one queue past full, then drain it past empty
    task automatic test_fill_drain();
        int q;
        q = $urandom_range(0, NUM_QUEUES - 1);
        repeat (QUEUE_DEPTH + 2)
            send_word(OP_ENQ, PORT_W'(q / QUEUES_PER_PORT), QSEL_W'(q % QUEUES_PER_PORT),
                      HANDLE_W'($urandom()), $urandom());
        repeat (QUEUE_DEPTH + 2)
            send_word(OP_DEQ, PORT_W'(q / QUEUES_PER_PORT), QSEL_W'(q % QUEUES_PER_PORT),
                      HANDLE_W'($urandom()), $urandom());
    endtask

    // phases of enqueue-heavy, balanced and dequeue-heavy traffic, some on one queue
    task automatic test_random_mix(input int n_words);
        int                sent;
        int                phase_len;
        int                enq_pct;
        int                focus_q;
        int                q;
        logic              kind;
        logic [PORT_W-1:0] port;
        logic [QSEL_W-1:0] qsel;
        sent = 0;
        while (sent < n_words) begin
            phase_len = $urandom_range(40, 150);
            case ($urandom_range(0, 2))
                0: enq_pct = 85;
                1: enq_pct = 50;
                default: enq_pct = 20;
            endcase
            // focus value NUM_QUEUES spreads the phase over all queues
            focus_q = $urandom_range(0, NUM_QUEUES);
            repeat (phase_len) begin
                if (sent >= n_words - QUIET_WORDS) idle_en = 1'b0;
                kind = ($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ;
                if ($urandom_range(0, 19) == 0) begin
                    port = PORT_W'($urandom());
                    qsel = QSEL_W'($urandom());
                end else begin
                    if (focus_q < NUM_QUEUES && $urandom_range(0, 4) != 0) q = focus_q;
                    else q = $urandom_range(0, NUM_QUEUES - 1);
                    port = PORT_W'(q / QUEUES_PER_PORT);
                    qsel = QSEL_W'(q % QUEUES_PER_PORT);
                end
                send_word(kind, port, qsel, HANDLE_W'($urandom()), $urandom());
                sent++;
            end
        end
    endtask

    // result receiver stalls in random bursts
    initial begin : ready_driver
        int run_len;
        m_ready = 1'b1;
        forever begin
            run_len = $urandom_range(1, 40);
            repeat (run_len) @(negedge aclk);
            if (idle_en && $urandom_range(0, 2) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge aclk);
                m_ready <= 1'b1;
            end
        end
    end

    // compare each result word with the oldest owed result
    always @(posedge aclk) begin
        buffer_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (owed_results.size() == 0) begin
                report_mismatch("unexpected result", {m_status, m_out_handle}, '0);
            end else begin
                want = owed_results.pop_front();
                if (m_status !== want.status)
                    report_mismatch("status", m_status, want.status);
                if (m_out_handle !== want.handle)
                    report_mismatch("out_handle", m_out_handle, want.handle);
                if (m_out_stamp !== want.stamp)
                    report_mismatch("out_stamp", m_out_stamp, want.stamp);
                if (m_depth_seen !== want.seen)
                    report_mismatch("depth_seen", m_depth_seen, want.seen);
                if (m_peak_depth !== want.peak)
                    report_mismatch("peak_depth", m_peak_depth, want.peak);
                if (m_resident_total !== want.total)
                    report_mismatch("resident_total", m_resident_total, want.total);
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin : run_tests
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_kind          = OP_ENQ;
        s_port          = '0;
        s_queue_sel     = '0;
        s_packet_handle = '0;
        s_arrival_stamp = '0;
        for (int q = 0; q < NUM_QUEUES; q++) begin
            shadow_peak[q]  = '0;
            shadow_total[q] = '0;
        end
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed();
        hold_off_until_drained();
        test_fill_drain();
        test_random_mix(1250);

        // wait out the last results, then keep watching for strays
        s_valid <= 1'b0;
        while (owed_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
